// ----- rtl/nnls_pkg.sv -----
// Shared constants, types and helpers for the nearest-neighbor LED scaler.
package nnls_pkg;

  // Size limits
  localparam int MAX_SOURCE_DIM = 1024;
  localparam int MAX_MATRIX_DIM = 64;

  // Register field widths as seen on the configuration port
  localparam int REG_SRC_W  = 11;
  localparam int REG_MAT_W  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Internal widths
  localparam int SRC_DIM_W = $clog2(MAX_SOURCE_DIM + 1);
  localparam int SRC_CNT_W = $clog2(MAX_SOURCE_DIM);
  localparam int MAT_DIM_W = $clog2(MAX_MATRIX_DIM + 1);
  localparam int DIV_W     = SRC_DIM_W;
  localparam int QUO_W     = SRC_DIM_W;
  localparam int REM_W     = MAT_DIM_W;
  localparam int STEP_W    = $clog2(DIV_W + 1);

  // Result field widths
  localparam int TGT_W   = 6;
  localparam int SPAN_W  = 7;
  localparam int COLOR_W = 8;

  // Stream word layout
  localparam int S_FIELDS_W = 3 * COLOR_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = 2 * TGT_W + SPAN_W + 3 * COLOR_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int SPAN_LO    = 2 * TGT_W;
  localparam int SPAN_HI    = SPAN_LO + SPAN_W - 1;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Reset configuration: 16x16 source to 16x16 matrix, downsample
  localparam int RST_SRC_DIM = 16;
  localparam int RST_MAT_DIM = 16;
  localparam int RST_QUO     = RST_SRC_DIM / RST_MAT_DIM;
  localparam int RST_REM     = RST_SRC_DIM % RST_MAT_DIM;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION     = 3'd0,
    CFG_SOURCE_WIDTH  = 3'd1,
    CFG_SOURCE_HEIGHT = 3'd2,
    CFG_MATRIX_WIDTH  = 3'd3,
    CFG_MATRIX_HEIGHT = 3'd4
  } cfg_reg_e;

  // One span job: base row, column, span, number of rows and color
  typedef struct packed {
    logic [TGT_W-1:0]     row;
    logic [TGT_W-1:0]     col;
    logic [SPAN_W-1:0]    span;
    logic [MAT_DIM_W-1:0] rows;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
  } job_t;

  // Zero reads as one, oversize as the maximum
  function automatic logic [SRC_DIM_W-1:0] clamp_src(input logic [REG_SRC_W-1:0] v);
    logic [SRC_DIM_W-1:0] res;
    if (v == '0) begin
      res = SRC_DIM_W'(1);
    end else if (int'(v) > MAX_SOURCE_DIM) begin
      res = SRC_DIM_W'(MAX_SOURCE_DIM);
    end else begin
      res = SRC_DIM_W'(v);
    end
    return res;
  endfunction

  function automatic logic [MAT_DIM_W-1:0] clamp_mat(input logic [REG_MAT_W-1:0] v);
    logic [MAT_DIM_W-1:0] res;
    if (v == '0) begin
      res = MAT_DIM_W'(1);
    end else if (int'(v) > MAX_MATRIX_DIM) begin
      res = MAT_DIM_W'(MAX_MATRIX_DIM);
    end else begin
      res = MAT_DIM_W'(v);
    end
    return res;
  endfunction

endpackage

// ----- rtl/nnls_div.sv -----
// Restoring divider, one quotient bit per cycle.
module nnls_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [nnls_pkg::DIV_W-1:0] dividend_i,
  input  logic [nnls_pkg::DIV_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [nnls_pkg::DIV_W-1:0] quo_o,
  output logic [nnls_pkg::DIV_W-1:0] rem_o
);

  logic [nnls_pkg::STEP_W-1:0] cnt_q;
  logic                        done_q;
  logic [nnls_pkg::DIV_W-1:0]  dvd_q, dvs_q, quo_q, rem_q;
  logic [nnls_pkg::DIV_W:0]    trial, diff;
  logic                        fits;

  // Bring down the next dividend bit and try the subtract
  assign trial = {rem_q, dvd_q[nnls_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  // Step counter; a new start always wins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= nnls_pkg::STEP_W'(nnls_pkg::DIV_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == nnls_pkg::STEP_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // Operand and result shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      quo_q <= '0;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= {dvd_q[nnls_pkg::DIV_W-2:0], 1'b0};
      quo_q <= {quo_q[nnls_pkg::DIV_W-2:0], fits};
      rem_q <= fits ? diff[nnls_pkg::DIV_W-1:0] : trial[nnls_pkg::DIV_W-1:0];
    end
  end

  assign busy_o = (cnt_q != '0) | done_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/nnls_queue.sv -----
// Small job FIFO between the pixel front end and the span emitter.
module nnls_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  nnls_pkg::job_t      job_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output nnls_pkg::job_t      head_o
);

  nnls_pkg::job_t                mem_q [nnls_pkg::QUEUE_DEPTH];
  logic [nnls_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [nnls_pkg::QCNT_W-1:0]   cnt_q;

  function automatic logic [nnls_pkg::QPTR_W-1:0] ptr_inc(
    input logic [nnls_pkg::QPTR_W-1:0] p
  );
    logic [nnls_pkg::QPTR_W-1:0] res;
    if (p == nnls_pkg::QPTR_W'(nnls_pkg::QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = p + 1'b1;
    end
    return res;
  endfunction

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  assign full_o  = (cnt_q == nnls_pkg::QCNT_W'(nnls_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

endmodule

// ----- rtl/nnls_front.sv -----
// Front end: configuration, axis divisions and per-pixel position tracking.
module nnls_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [nnls_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [nnls_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_valid_i,
  input  logic [nnls_pkg::S_TDATA_W-1:0]   s_data_i,
  output logic                             s_ready_o,
  input  logic                             full_i,
  output logic                             push_o,
  output nnls_pkg::job_t                   job_o
);

  localparam int SW = nnls_pkg::SRC_DIM_W;
  localparam int CW = nnls_pkg::SRC_CNT_W;
  localparam int MW = nnls_pkg::MAT_DIM_W;
  localparam int QW = nnls_pkg::QUO_W;
  localparam int RW = nnls_pkg::REM_W;
  localparam int DW = nnls_pkg::DIV_W;

  // Configuration (dimensions kept clamped)
  logic          dir_q, dir_d;
  logic [SW-1:0] src_w_q, src_w_d, src_h_q, src_h_d;
  logic [MW-1:0] mat_w_q, mat_w_d, mat_h_q, mat_h_d;
  logic          cfg_hit;

  // Derived per-axis quotient and remainder
  logic [QW-1:0] col_quo_q, row_quo_q;
  logic [RW-1:0] col_rem_q, row_rem_q;

  // Position state
  logic [CW-1:0] src_col_q, src_col_d, src_row_q, src_row_d;
  logic [SW-1:0] pick_col_q, pick_col_d, pick_row_q, pick_row_d;
  logic [MW-1:0] mcol_q, mcol_d, mrow_q, mrow_d;

  // Divider hookup
  logic [DW-1:0] col_dvd, col_dvs, row_dvd, row_dvs;
  logic [DW-1:0] col_quo, col_rem, row_quo, row_rem;
  logic          col_busy, col_done, row_busy, row_done;

  // Per-pixel decode
  logic          accept, emit;
  logic          col_end, row_end, row_hit, col_hit;
  logic [MW-1:0] mcol_inc, mrow_inc;
  logic [SW-1:0] pick_col_adv, pick_row_adv;
  logic          col_tail, row_tail;
  logic [QW-1:0] span_full, rows_full;
  logic          span_nz;
  logic [MW-1:0] rows_adv;

  // Register write decode
  always_comb begin
    dir_d   = dir_q;
    src_w_d = src_w_q;
    src_h_d = src_h_q;
    mat_w_d = mat_w_q;
    mat_h_d = mat_h_q;
    cfg_hit = 1'b0;
    if (cfg_valid_i) begin
      unique case (nnls_pkg::cfg_reg_e'(cfg_index_i))
        nnls_pkg::CFG_DIRECTION: begin
          dir_d   = cfg_data_i[0];
          cfg_hit = 1'b1;
        end
        nnls_pkg::CFG_SOURCE_WIDTH: begin
          src_w_d = nnls_pkg::clamp_src(cfg_data_i[nnls_pkg::REG_SRC_W-1:0]);
          cfg_hit = 1'b1;
        end
        nnls_pkg::CFG_SOURCE_HEIGHT: begin
          src_h_d = nnls_pkg::clamp_src(cfg_data_i[nnls_pkg::REG_SRC_W-1:0]);
          cfg_hit = 1'b1;
        end
        nnls_pkg::CFG_MATRIX_WIDTH: begin
          mat_w_d = nnls_pkg::clamp_mat(cfg_data_i[nnls_pkg::REG_MAT_W-1:0]);
          cfg_hit = 1'b1;
        end
        nnls_pkg::CFG_MATRIX_HEIGHT: begin
          mat_h_d = nnls_pkg::clamp_mat(cfg_data_i[nnls_pkg::REG_MAT_W-1:0]);
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // Source size over matrix size per axis when downsampling, matrix over source when upsampling
  assign col_dvd = dir_d ? DW'(mat_w_d) : DW'(src_w_d);
  assign col_dvs = dir_d ? DW'(src_w_d) : DW'(mat_w_d);
  assign row_dvd = dir_d ? DW'(mat_h_d) : DW'(src_h_d);
  assign row_dvs = dir_d ? DW'(src_h_d) : DW'(mat_h_d);

  nnls_div u_div_col (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_hit),
    .dividend_i (col_dvd),
    .divisor_i  (col_dvs),
    .busy_o     (col_busy),
    .done_o     (col_done),
    .quo_o      (col_quo),
    .rem_o      (col_rem)
  );

  nnls_div u_div_row (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_hit),
    .dividend_i (row_dvd),
    .divisor_i  (row_dvs),
    .busy_o     (row_busy),
    .done_o     (row_done),
    .quo_o      (row_quo),
    .rem_o      (row_rem)
  );

  // Hold off pixels while a division runs, a write is on the port or the job queue is full
  assign s_ready_o = ~col_busy & ~row_busy & ~cfg_valid_i & ~full_i;
  assign accept    = s_valid_i & s_ready_o;

  // Shared end-of-line tests
  assign col_end = (SW'(src_col_q) == src_w_q - SW'(1));
  assign row_end = (SW'(src_row_q) == src_h_q - SW'(1));

  // Downsample pick tests and next pick positions
  assign row_hit  = (SW'(src_row_q) == pick_row_q) && (mrow_q < mat_h_q);
  assign col_hit  = (SW'(src_col_q) == pick_col_q) && (mcol_q < mat_w_q);
  assign mcol_inc = mcol_q + 1'b1;
  assign mrow_inc = mrow_q + 1'b1;
  assign pick_col_adv = pick_col_q + SW'(col_quo_q)
                      + SW'(mcol_inc >= mat_w_q - MW'(col_rem_q));
  assign pick_row_adv = pick_row_q + SW'(row_quo_q)
                      + SW'(mrow_inc >= mat_h_q - MW'(row_rem_q));

  // Upsample span and row count, one more on the trailing remainder positions
  assign col_tail  = SW'(src_col_q) >= src_w_q - SW'(col_rem_q);
  assign row_tail  = SW'(src_row_q) >= src_h_q - SW'(row_rem_q);
  assign span_full = col_quo_q + QW'(col_tail);
  assign rows_full = row_quo_q + QW'(row_tail);
  assign span_nz   = (span_full != '0);
  assign rows_adv  = (span_nz && rows_full > QW'(nnls_pkg::MAX_MATRIX_DIM)) ?
                     MW'(nnls_pkg::MAX_MATRIX_DIM) : rows_full[MW-1:0];

  // Next positions for an accepted pixel
  always_comb begin
    src_col_d  = src_col_q;
    src_row_d  = src_row_q;
    pick_col_d = pick_col_q;
    pick_row_d = pick_row_q;
    mcol_d     = mcol_q;
    mrow_d     = mrow_q;
    if (!dir_q) begin
      emit = row_hit & col_hit;
      if (col_hit) begin
        mcol_d     = mcol_inc;
        pick_col_d = pick_col_adv;
      end
    end else begin
      emit   = span_nz && (rows_adv != '0);
      mcol_d = mcol_q + span_full[MW-1:0];
    end
    if (col_end) begin
      src_col_d  = '0;
      pick_col_d = '0;
      mcol_d     = '0;
      if (!dir_q) begin
        if (row_hit) begin
          mrow_d     = mrow_inc;
          pick_row_d = pick_row_adv;
        end
      end else begin
        mrow_d = mrow_q + rows_adv;
      end
      if (row_end) begin
        // frame done: everything back to the origin
        src_row_d  = '0;
        pick_row_d = '0;
        mrow_d     = '0;
      end else begin
        src_row_d = src_row_q + 1'b1;
      end
    end else begin
      src_col_d = src_col_q + 1'b1;
    end
  end

  // Job word
  always_comb begin
    job_o.row   = mrow_q[nnls_pkg::TGT_W-1:0];
    job_o.col   = mcol_q[nnls_pkg::TGT_W-1:0];
    job_o.span  = dir_q ? span_full[nnls_pkg::SPAN_W-1:0] : nnls_pkg::SPAN_W'(1);
    job_o.rows  = dir_q ? rows_adv : MW'(1);
    job_o.red   = s_data_i[nnls_pkg::COLOR_W-1:0];
    job_o.green = s_data_i[2*nnls_pkg::COLOR_W-1:nnls_pkg::COLOR_W];
    job_o.blue  = s_data_i[3*nnls_pkg::COLOR_W-1:2*nnls_pkg::COLOR_W];
  end

  assign push_o = accept & emit;

  // Configuration and derived values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q     <= 1'b0;
      src_w_q   <= SW'(nnls_pkg::RST_SRC_DIM);
      src_h_q   <= SW'(nnls_pkg::RST_SRC_DIM);
      mat_w_q   <= MW'(nnls_pkg::RST_MAT_DIM);
      mat_h_q   <= MW'(nnls_pkg::RST_MAT_DIM);
      col_quo_q <= QW'(nnls_pkg::RST_QUO);
      col_rem_q <= RW'(nnls_pkg::RST_REM);
      row_quo_q <= QW'(nnls_pkg::RST_QUO);
      row_rem_q <= RW'(nnls_pkg::RST_REM);
    end else begin
      dir_q   <= dir_d;
      src_w_q <= src_w_d;
      src_h_q <= src_h_d;
      mat_w_q <= mat_w_d;
      mat_h_q <= mat_h_d;
      if (col_done) begin
        col_quo_q <= QW'(col_quo);
        col_rem_q <= RW'(col_rem);
      end
      if (row_done) begin
        row_quo_q <= QW'(row_quo);
        row_rem_q <= RW'(row_rem);
      end
    end
  end

  // Position counters; a write to a mapped register restarts the frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q  <= '0;
      src_row_q  <= '0;
      pick_col_q <= '0;
      pick_row_q <= '0;
      mcol_q     <= '0;
      mrow_q     <= '0;
    end else if (cfg_hit) begin
      src_col_q  <= '0;
      src_row_q  <= '0;
      pick_col_q <= '0;
      pick_row_q <= '0;
      mcol_q     <= '0;
      mrow_q     <= '0;
    end else if (accept) begin
      src_col_q  <= src_col_d;
      src_row_q  <= src_row_d;
      pick_col_q <= pick_col_d;
      pick_row_q <= pick_row_d;
      mcol_q     <= mcol_d;
      mrow_q     <= mrow_d;
    end
  end

endmodule

// ----- rtl/nnls_back.sv -----
// Back end: expands each job into one span word per destination row.
module nnls_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  nnls_pkg::job_t                 head_i,
  output logic                           pop_o,
  output logic                           m_valid_o,
  input  logic                           m_ready_i,
  output logic [nnls_pkg::M_TDATA_W-1:0] m_data_o,
  output logic                           m_last_o
);

  localparam int TW = nnls_pkg::TGT_W;
  localparam int MW = nnls_pkg::MAT_DIM_W;
  localparam int KW = nnls_pkg::TGT_W;

  nnls_pkg::job_t                 cur_q;
  logic                           cur_valid_q;
  logic [KW-1:0]                  k_q;
  logic                           out_valid_q, out_last_q;
  logic [nnls_pkg::M_TDATA_W-1:0] out_data_q;
  logic                           load_out, cur_last, finish;
  logic [TW-1:0]                  row_now;

  // Emit a row when the output register is free or being drained
  assign load_out = cur_valid_q & (~out_valid_q | m_ready_i);
  assign cur_last = ((MW'(k_q) + 1'b1) == cur_q.rows);
  assign finish   = load_out & cur_last;
  assign pop_o    = ~empty_i & (~cur_valid_q | finish);
  assign row_now  = cur_q.row + k_q;

  // Current job and row counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      k_q         <= '0;
    end else if (pop_o) begin
      cur_valid_q <= 1'b1;
      k_q         <= '0;
    end else if (finish) begin
      cur_valid_q <= 1'b0;
    end else if (load_out) begin
      k_q <= k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= nnls_pkg::M_TDATA_W'({cur_q.blue, cur_q.green, cur_q.red,
                                          cur_q.span, cur_q.col, row_now});
      out_last_q <= cur_last;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;

endmodule

// ----- rtl/nearest_neighbor_led_scaler.sv -----
// Top level of the nearest-neighbor LED scaler.
// A pixel that yields output passes the job queue, current-job and output registers.
// Downsampling takes one pixel per cycle while the queue has room and no division or
// register write holds the input; the span emitter puts out one destination row a cycle
// while the output is ready. A mapped register write restarts the frame and runs both axis
// dividers, taking no pixel meanwhile. Reset (async, low): 16x16 to 16x16 downsample.
module nearest_neighbor_led_scaler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [nnls_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [nnls_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pixel_red, pixel_green, pixel_blue
  input  logic [nnls_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // target_row, target_column, span_length, out_red, out_green, out_blue, zero pad
  output logic [nnls_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // last_of_run
  output logic                             m_axis_tlast
);

  nnls_pkg::job_t push_job, head_job;
  logic           push, pop, full, empty;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  nnls_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_valid_i   (s_axis_tvalid),
    .s_data_i    (s_axis_tdata),
    .s_ready_o   (s_axis_tready),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  nnls_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_job)
  );

  nnls_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .head_i    (head_job),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

endmodule

// ----- rtl/nnls_checker.sv -----
// Port-level checks for the LED scaler, bound to the top level.
module nnls_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o,
  input logic [nnls_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [nnls_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input logic                             m_axis_tlast
);

  // No pixel is taken while a register write is on the port
  a_cfg_blocks_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> !s_axis_tready)
    else $error("pixel input open during a register write");

  // A write to a mapped register starts the divisions, so input stays closed the next cycle
  a_derive_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && (cfg_index_i <= nnls_pkg::CFG_MATRIX_HEIGHT))
    |=> !s_axis_tready)
    else $error("pixel input open while axis divisions run");

  // Every span covers at least one column
  a_span_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[nnls_pkg::SPAN_HI:nnls_pkg::SPAN_LO] != '0))
    else $error("span word with zero length");

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
    (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output word changed while stalled");

endmodule

bind nearest_neighbor_led_scaler nnls_checker u_nnls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .cfg_index_i   (cfg_index_i),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- verif/nnls_span_checker.sv -----
// Checker for the LED scaler: predicts span words from observed traffic and compares them.
module nnls_span_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [nnls_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nnls_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            pix_valid_i,
  input  logic                            pix_ready_i,
  // pixel_red, pixel_green, pixel_blue
  input  logic [nnls_pkg::S_TDATA_W-1:0]  pix_data_i,
  input  logic                            span_valid_i,
  input  logic                            span_ready_i,
  // target_row, target_column, span_length, out_red, out_green, out_blue, zero pad
  input  logic [nnls_pkg::M_TDATA_W-1:0]  span_data_i,
  input  logic                            span_last_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import nnls_pkg::*;

  typedef struct packed {
    logic [TGT_W-1:0]   row;
    logic [TGT_W-1:0]   col;
    logic [SPAN_W-1:0]  span;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
  } span_word_t;

  // Shadow of the register file
  logic                 scale_up;
  logic [REG_SRC_W-1:0] reg_src_w, reg_src_h;
  logic [REG_MAT_W-1:0] reg_mat_w, reg_mat_h;

  // Effective sizes and per-axis ratios
  logic [SRC_DIM_W-1:0] src_w, src_h;
  logic [MAT_DIM_W-1:0] mat_w, mat_h;
  logic [SRC_DIM_W-1:0] col_q, col_r, row_q, row_r;

  // Frame position
  logic [SRC_DIM_W-1:0] src_col, src_row, pick_col, pick_row;
  logic [MAT_DIM_W:0]   mat_col, mat_row;

  span_word_t span_q[$];
  span_word_t got, want;
  logic [M_TDATA_W-M_FIELDS_W-1:0] pad;

  function automatic void restart_frame();
    src_col  = '0;
    src_row  = '0;
    pick_col = '0;
    pick_row = '0;
    mat_col  = '0;
    mat_row  = '0;
  endfunction

  // Zero counts as one, oversize as the limit; ratio: source/matrix down, matrix/source up
  function automatic void derive_ratios();
    src_w = (reg_src_w == 0) ? 1 : (reg_src_w > MAX_SOURCE_DIM) ? MAX_SOURCE_DIM : reg_src_w;
    src_h = (reg_src_h == 0) ? 1 : (reg_src_h > MAX_SOURCE_DIM) ? MAX_SOURCE_DIM : reg_src_h;
    mat_w = (reg_mat_w == 0) ? 1 : (reg_mat_w > MAX_MATRIX_DIM) ? MAX_MATRIX_DIM : reg_mat_w;
    mat_h = (reg_mat_h == 0) ? 1 : (reg_mat_h > MAX_MATRIX_DIM) ? MAX_MATRIX_DIM : reg_mat_h;
    if (!scale_up) begin
      col_q = src_w / mat_w;
      col_r = src_w % mat_w;
      row_q = src_h / mat_h;
      row_r = src_h % mat_h;
    end else begin
      col_q = mat_w / src_w;
      col_r = mat_w % src_w;
      row_q = mat_h / src_h;
      row_r = mat_h % src_h;
    end
    restart_frame();
  endfunction

  // Step past one source column; wraps rows and the frame
  function automatic void next_column(input logic row_adv, input logic [SRC_DIM_W-1:0] row_step);
    src_col = src_col + 1;
    if (src_col >= src_w) begin
      src_col  = '0;
      pick_col = '0;
      mat_col  = '0;
      if (row_adv) begin
        if (!scale_up) begin
          mat_row  = mat_row + 1;
          pick_row = pick_row + row_q + ((mat_row >= mat_h - row_r) ? 1 : 0);
        end else begin
          mat_row = mat_row + row_step;
        end
      end
      src_row = src_row + 1;
      if (src_row >= src_h) restart_frame();
    end
  endfunction

  // Queue the span words one source pixel produces
  function automatic void scale_pixel(input logic [S_TDATA_W-1:0] rgb);
    span_word_t           w;
    logic                 row_hit, col_hit;
    logic [SRC_DIM_W-1:0] span, rows;
    int                   k;
    w.red   = rgb[COLOR_W-1:0];
    w.green = rgb[2*COLOR_W-1:COLOR_W];
    w.blue  = rgb[3*COLOR_W-1:2*COLOR_W];
    if (!scale_up) begin
      row_hit = (src_row == pick_row) && (mat_row < mat_h);
      col_hit = (src_col == pick_col) && (mat_col < mat_w);
      if (row_hit && col_hit) begin
        w.row  = TGT_W'(mat_row);
        w.col  = TGT_W'(mat_col);
        w.span = SPAN_W'(1);
        w.last = 1'b1;
        span_q.push_back(w);
      end
      if (col_hit) begin
        mat_col  = mat_col + 1;
        pick_col = pick_col + col_q + ((mat_col >= mat_w - col_r) ? 1 : 0);
      end
      next_column(row_hit, '0);
    end else begin
      // last remainder columns and rows get one extra
      span = col_q + ((src_col >= src_w - col_r) ? 1 : 0);
      rows = row_q + ((src_row >= src_h - row_r) ? 1 : 0);
      if (span > 0 && rows > MAX_MATRIX_DIM) rows = MAX_MATRIX_DIM;
      if (span > 0) begin
        for (k = 0; k < rows; k++) begin
          w.row  = TGT_W'(mat_row + k);
          w.col  = TGT_W'(mat_col);
          w.span = SPAN_W'(span);
          w.last = (k + 1 == rows);
          span_q.push_back(w);
        end
      end
      mat_col = mat_col + span;
      next_column(1'b1, rows);
    end
  endfunction

  // Config and pixel words update the prediction before the output word is checked
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_up  = 1'b0;
      reg_src_w = REG_SRC_W'(RST_SRC_DIM);
      reg_src_h = REG_SRC_W'(RST_SRC_DIM);
      reg_mat_w = REG_MAT_W'(RST_MAT_DIM);
      reg_mat_h = REG_MAT_W'(RST_MAT_DIM);
      derive_ratios();
      span_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_DIRECTION: begin
            scale_up = cfg_data_i[0];
            derive_ratios();
          end
          CFG_SOURCE_WIDTH: begin
            reg_src_w = cfg_data_i[REG_SRC_W-1:0];
            derive_ratios();
          end
          CFG_SOURCE_HEIGHT: begin
            reg_src_h = cfg_data_i[REG_SRC_W-1:0];
            derive_ratios();
          end
          CFG_MATRIX_WIDTH: begin
            reg_mat_w = cfg_data_i[REG_MAT_W-1:0];
            derive_ratios();
          end
          CFG_MATRIX_HEIGHT: begin
            reg_mat_h = cfg_data_i[REG_MAT_W-1:0];
            derive_ratios();
          end
          default: ;  // unmapped index: no effect
        endcase
      end

      if (pix_valid_i && pix_ready_i) scale_pixel(pix_data_i);

      if (span_valid_i && span_ready_i) begin
        got.row   = span_data_i[TGT_W-1:0];
        got.col   = span_data_i[2*TGT_W-1:TGT_W];
        got.span  = span_data_i[SPAN_HI:SPAN_LO];
        got.red   = span_data_i[SPAN_HI+1 +: COLOR_W];
        got.green = span_data_i[SPAN_HI+1+COLOR_W +: COLOR_W];
        got.blue  = span_data_i[SPAN_HI+1+2*COLOR_W +: COLOR_W];
        got.last  = span_last_i;
        pad       = span_data_i[M_TDATA_W-1:M_FIELDS_W];
        if (span_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: span word with none pending: %h last %b",
                     $realtime, span_data_i, span_last_i);
        end else begin
          want = span_q.pop_front();
          if (got.row !== want.row || got.col !== want.col || got.span !== want.span ||
              got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.last !== want.last || pad !== '0) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"%0t: span word mismatch (exp/got): row %0d/%0d col %0d/%0d ",
                        "span %0d/%0d rgb %h%h%h/%h%h%h last %b/%b pad %h"},
                       $realtime, want.row, got.row, want.col, got.col,
                       want.span, got.span, want.red, want.green, want.blue,
                       got.red, got.green, got.blue, want.last, got.last, pad);
          end
        end
      end
    end
    pending_o = span_q.size();
  end

endmodule

// ----- verif/tb_nearest_neighbor_led_scaler.sv -----
// Stimulus and verdict for the nearest-neighbor LED scaler, checked by nnls_span_checker.
module tb_nearest_neighbor_led_scaler;
  import nnls_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 16;
  localparam int PIXEL_COUNT  = 430;
  localparam int LIMIT_CYCLES = 400_000;
  // window of pixels sent with no input gaps and the output always ready
  localparam int STEADY_FROM  = 180;
  localparam int STEADY_TO    = 280;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tlast;

  int   fail_count;
  int   pending_spans;
  int   pixels_sent = 0;
  logic no_idle     = 1'b0;

  nearest_neighbor_led_scaler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  nnls_span_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pix_valid_i  (s_axis_tvalid),
    .pix_ready_i  (s_axis_tready),
    .pix_data_i   (s_axis_tdata),
    .span_valid_i (m_axis_tvalid),
    .span_ready_i (m_axis_tready),
    .span_data_i  (m_axis_tdata),
    .span_last_i  (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending_spans)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Output side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 33);
  end

  // One register word; valid drops before the task returns so the next write starts clean
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Program the registers (unless kept), stream pixels, then wait for the block to drain
  task automatic run_phase(input logic [CFG_DATA_W-1:0] dir, input logic [CFG_DATA_W-1:0] sw,
                           input logic [CFG_DATA_W-1:0] sh, input logic [CFG_DATA_W-1:0] mw,
                           input logic [CFG_DATA_W-1:0] mh, input int n_pixels,
                           input bit patterned, input bit program_regs);
    logic [CFG_DATA_W-1:0] vals [CFG_MATRIX_HEIGHT+1];
    logic [CFG_IDX_W-1:0]  idx;
    logic [S_TDATA_W-1:0]  rgb;
    int                    first;
    int                    j;
    vals[CFG_DIRECTION]     = dir;
    vals[CFG_SOURCE_WIDTH]  = sw;
    vals[CFG_SOURCE_HEIGHT] = sh;
    vals[CFG_MATRIX_WIDTH]  = mw;
    vals[CFG_MATRIX_HEIGHT] = mh;
    if (program_regs) begin
      // now and then a write to an unmapped index, which must change nothing
      if (!patterned && $urandom_range(0, 4) == 0)
        write_reg(CFG_IDX_W'(CFG_MATRIX_HEIGHT + $urandom_range(1, 3)), CFG_DATA_W'($urandom));
      first = $urandom_range(0, CFG_MATRIX_HEIGHT);
      for (j = 0; j <= CFG_MATRIX_HEIGHT; j++) begin
        idx = CFG_IDX_W'((first + j) % (CFG_MATRIX_HEIGHT + 1));
        write_reg(idx, vals[idx]);
      end
    end

    for (j = 0; j < n_pixels; j++) begin
      if (patterned) begin
        case (j % 6)
          0:       rgb = 24'h000000;
          1:       rgb = 24'hFFFFFF;
          2:       rgb = 24'h0000FF;
          3:       rgb = 24'hFF00FF;
          4:       rgb = 24'h00FF00;
          default: rgb = 24'h5AA5C3;
        endcase
      end else begin
        rgb = S_TDATA_W'($urandom);
      end
      no_idle <= (pixels_sent >= STEADY_FROM && pixels_sent < STEADY_TO);
      // random gap before the word
      while (!no_idle && $urandom_range(0, 99) < 33) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= rgb;
      do @(negedge clk_i); while (!s_axis_tready);
      @(posedge clk_i);
      pixels_sent++;
    end
    s_axis_tvalid <= 1'b0;

    do @(negedge clk_i); while (pending_spans != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("FAIL nearest_neighbor_led_scaler");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] dir, sw, sh, mw, mh;
    int                    shape, esw, esh, frame, n;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, remainders on both axes, widest span, mixed scaling
    run_phase(0, 16, 16, 16, 16, 3, 1'b1, 1'b0);
    run_phase(0, 3, 2, 2, 1, 6, 1'b1, 1'b1);
    run_phase(1, 1, 1, 64, 64, 1, 1'b1, 1'b1);
    run_phase(1, 3, 2, 5, 3, 6, 1'b1, 1'b1);
    run_phase(0, 2, 2, 3, 3, 4, 1'b1, 1'b1);
    run_phase(1, 4, 1, 2, 1, 4, 1'b1, 1'b1);

    // Size extremes and out-of-range codes, random colors
    run_phase(0, 2047, 1025, 64, 64, 40, 1'b0, 1'b1);
    run_phase(1, 0, 2, 127, 11'h781, 6, 1'b0, 1'b1);
    run_phase(0, 5, 5, 11'h780, 2, 25, 1'b0, 1'b1);
    run_phase(11'h7FF, 1, 1, 1, 1, 3, 1'b0, 1'b1);

    // Random settings, mostly well-formed down or up scaling with small sizes
    while (pixels_sent < PIXEL_COUNT) begin
      shape = $urandom_range(0, 9);
      dir   = CFG_DATA_W'($urandom_range(0, 1));
      if (shape == 0) begin
        sw = $urandom_range(1, 9);
        sh = $urandom_range(1, 9);
        mw = $urandom_range(1, 9);
        mh = $urandom_range(1, 9);
      end else if (shape == 1) begin
        sw = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_SOURCE_DIM + 1, 2047);
        sh = $urandom_range(1, 3);
        mw = ($urandom_range(0, 1) ? 0 : $urandom_range(MAX_MATRIX_DIM + 1, 127))
             | ($urandom_range(0, 15) << REG_MAT_W);
        mh = $urandom_range(1, MAX_MATRIX_DIM) | ($urandom_range(0, 15) << REG_MAT_W);
      end else if (shape == 2) begin
        dir = 1;
        sw  = $urandom_range(1, 3);
        sh  = $urandom_range(1, 3);
        mw  = MAX_MATRIX_DIM;
        mh  = MAX_MATRIX_DIM;
      end else if (dir[0] == 1'b0) begin
        mw = $urandom_range(1, 8);
        sw = $urandom_range(mw, 3 * mw + 2);
        mh = $urandom_range(1, 8);
        sh = $urandom_range(mh, 3 * mh + 2);
      end else begin
        sw = $urandom_range(1, 4);
        mw = $urandom_range(sw, 8 * sw);
        sh = $urandom_range(1, 4);
        mh = $urandom_range(sh, 8 * sh);
      end
      // upper bits of the direction word are don't-care
      dir = dir | CFG_DATA_W'($urandom_range(0, 1023) << 1);

      esw   = (sw == 0) ? 1 : (sw > MAX_SOURCE_DIM) ? MAX_SOURCE_DIM : sw;
      esh   = (sh == 0) ? 1 : (sh > MAX_SOURCE_DIM) ? MAX_SOURCE_DIM : sh;
      frame = esw * esh;
      if (frame <= 48) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, frame)
                                         : frame * $urandom_range(1, 2);
      end else begin
        n = $urandom_range(10, 40);
      end
      run_phase(dir, sw, sh, mw, mh, n, 1'b0, 1'b1);
    end

    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS nearest_neighbor_led_scaler");
    end else begin
      $display("FAIL nearest_neighbor_led_scaler");
    end
    $finish;
  end

endmodule
